// File: src/tht_pkg.sv
// ----------------------------------------------------------------------------
// Tilt gesture debouncer package
// Shared item types, register map, gesture codes and fixed-point constants.
// ----------------------------------------------------------------------------
package tht_pkg;

  // Gesture codes as they appear on the result channel.
  typedef enum logic [2:0] {
    GEST_NONE      = 3'd0,
    GEST_BOTH_UP   = 3'd1,
    GEST_BOTH_DOWN = 3'd2,
    GEST_CROSSED   = 3'd3,
    GEST_HELP      = 3'd4
  } gesture_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_ROLL_CROSS   = 3'd0,
    REG_HELP_LIFT    = 3'd1,
    REG_HELP_NEUTRAL = 3'd2,
    REG_LIFT         = 3'd3,
    REG_LOWER        = 3'd4,
    REG_HOLD_TIME    = 3'd5,
    REG_STALE_LIMIT  = 3'd6
  } reg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Width of the scaled confidence before the divide by 45.
  localparam int unsigned DivdW   = 23;
  // Reciprocal of 45 scaled by 2^29, rounded up; exact for dividends below 2^23.
  localparam int unsigned RecipW  = 24;
  localparam int unsigned RecipSh = 29;
  localparam logic [RecipW-1:0] RECIP_45 = 24'd11930465;
  localparam int unsigned ProdW   = DivdW + RecipW;
  localparam int unsigned QuotW   = ProdW - RecipSh;

  // Confidence of 1.0.
  localparam logic [15:0] CONF_ONE = 16'd32768;

  // Register reset values.
  localparam logic [14:0]        ROLL_CROSS_RST   = 15'd3840;
  localparam logic [14:0]        HELP_LIFT_RST    = 15'd3840;
  localparam logic [14:0]        HELP_NEUTRAL_RST = 15'd1920;
  localparam logic [14:0]        LIFT_RST         = 15'd3840;
  localparam logic signed [15:0] LOWER_RST        = -16'sd3840;
  localparam logic [15:0]        HOLD_TIME_RST    = 16'd500;
  localparam logic [15:0]        STALE_LIMIT_RST  = 16'd200;

  // One input item.
  typedef struct packed {
    logic signed [15:0] first_pitch;
    logic signed [15:0] first_roll;
    logic signed [15:0] second_pitch;
    logic signed [15:0] second_roll;
    logic [15:0]        frame_age_ms;
    logic [31:0]        now_ms;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [2:0]  gesture_code;
    logic [15:0] confidence;
  } result_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [14:0]        roll_cross_threshold;
    logic [14:0]        help_lift_threshold;
    logic [14:0]        help_neutral_limit;
    logic [14:0]        lift_threshold;
    logic signed [15:0] lower_threshold;
    logic [15:0]        hold_time_ms;
    logic [15:0]        stale_limit_ms;
  } cfg_t;

  // Classifier verdict handed to the debounce stage.
  typedef struct packed {
    gesture_e         cand;
    logic [DivdW-1:0] dividend;
  } cls_t;

  // Magnitude of a 16-bit two's complement value; the most negative value maps to 32768.
  function automatic logic [15:0] mag16(input logic [15:0] v);
    mag16 = v[15] ? (~v + 16'd1) : v;
  endfunction

endpackage

// File: src/tht_if.sv
// ----------------------------------------------------------------------------
// Tilt gesture debouncer channels
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface tht_in_if
  import tht_pkg::*;
;
  logic  valid;
  logic  ready;
  item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface tht_out_if
  import tht_pkg::*;
;
  logic    valid;
  logic    ready;
  result_t res;

  modport source (output valid, output res, input ready);
  modport sink   (input valid, input res, output ready);
endinterface

interface tht_cfg_if
  import tht_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/tht_cfg_regs.sv
// ----------------------------------------------------------------------------
// Tilt gesture debouncer register file
// Holds the thresholds and timing limits; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module tht_cfg_regs
  import tht_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  tht_cfg_if.sink   cfg_i,
  output cfg_t      cfg_o
);

  cfg_t cfg_q;

  // Writes are always taken.
  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  // Register file update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.roll_cross_threshold <= ROLL_CROSS_RST;
      cfg_q.help_lift_threshold  <= HELP_LIFT_RST;
      cfg_q.help_neutral_limit   <= HELP_NEUTRAL_RST;
      cfg_q.lift_threshold       <= LIFT_RST;
      cfg_q.lower_threshold      <= LOWER_RST;
      cfg_q.hold_time_ms         <= HOLD_TIME_RST;
      cfg_q.stale_limit_ms       <= STALE_LIMIT_RST;
    end else if (cfg_i.valid) begin
      case (reg_idx_e'(cfg_i.index))
        REG_ROLL_CROSS:   cfg_q.roll_cross_threshold <= cfg_i.data[14:0];
        REG_HELP_LIFT:    cfg_q.help_lift_threshold  <= cfg_i.data[14:0];
        REG_HELP_NEUTRAL: cfg_q.help_neutral_limit   <= cfg_i.data[14:0];
        REG_LIFT:         cfg_q.lift_threshold       <= cfg_i.data[14:0];
        REG_LOWER:        cfg_q.lower_threshold      <= $signed(cfg_i.data);
        REG_HOLD_TIME:    cfg_q.hold_time_ms         <= cfg_i.data;
        REG_STALE_LIMIT:  cfg_q.stale_limit_ms       <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

endmodule

// File: src/tht_classify.sv
// ----------------------------------------------------------------------------
// Tilt gesture classifier
// Applies the priority threshold rules and forms the scaled confidence dividend.
// ----------------------------------------------------------------------------
module tht_classify
  import tht_pkg::*;
(
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output cls_t  cls_o
);

  logic signed [16:0] fp_s, fr_s, sp_s, sr_s;
  logic signed [16:0] cross_s, neg_cross_s, help_lift_s, lift_s, lower_s;
  logic signed [16:0] pitch_sum_s;
  logic [15:0]        fp_mag, fr_mag, sp_mag, sr_mag;
  logic [15:0]        neutral;
  logic [16:0]        roll_sum, pitch_sum_mag;
  logic               is_crossed, is_help, is_up, is_down;

  // Sign-extend angles and thresholds to a common 17-bit signed range.
  assign fp_s        = $signed({item_i.first_pitch[15], item_i.first_pitch});
  assign fr_s        = $signed({item_i.first_roll[15], item_i.first_roll});
  assign sp_s        = $signed({item_i.second_pitch[15], item_i.second_pitch});
  assign sr_s        = $signed({item_i.second_roll[15], item_i.second_roll});
  assign cross_s     = $signed({2'b00, cfg_i.roll_cross_threshold});
  assign neg_cross_s = -cross_s;
  assign help_lift_s = $signed({2'b00, cfg_i.help_lift_threshold});
  assign lift_s      = $signed({2'b00, cfg_i.lift_threshold});
  assign lower_s     = $signed({cfg_i.lower_threshold[15], cfg_i.lower_threshold});
  assign neutral     = {1'b0, cfg_i.help_neutral_limit};

  // Magnitudes used by the help rule and the confidence terms.
  assign fp_mag        = mag16(item_i.first_pitch);
  assign fr_mag        = mag16(item_i.first_roll);
  assign sp_mag        = mag16(item_i.second_pitch);
  assign sr_mag        = mag16(item_i.second_roll);
  assign roll_sum      = {1'b0, fr_mag} + {1'b0, sr_mag};
  assign pitch_sum_s   = fp_s + sp_s;
  assign pitch_sum_mag = pitch_sum_s[16] ? 17'(-pitch_sum_s) : 17'(pitch_sum_s);

  // Rule conditions.
  assign is_crossed = (fr_s > cross_s) && (sr_s < neg_cross_s);
  assign is_help    = (sp_s > help_lift_s) && (fp_mag < neutral) && (fr_mag < neutral);
  assign is_up      = (fp_s > lift_s) && (sp_s > lift_s);
  assign is_down    = (fp_s < lower_s) && (sp_s < lower_s);

  // Priority pick and the matching dividend, which is later divided by 45.
  always_comb begin
    cls_o.cand     = GEST_NONE;
    cls_o.dividend = '0;
    if (is_crossed) begin
      cls_o.cand     = GEST_CROSSED;
      cls_o.dividend = {1'b0, roll_sum, 5'b0};
    end else if (is_help) begin
      cls_o.cand     = GEST_HELP;
      cls_o.dividend = {sp_mag, 7'b0};
    end else if (is_up) begin
      cls_o.cand     = GEST_BOTH_UP;
      cls_o.dividend = {pitch_sum_mag, 6'b0};
    end else if (is_down) begin
      cls_o.cand     = GEST_BOTH_DOWN;
      cls_o.dividend = {pitch_sum_mag, 6'b0};
    end
  end

endmodule

// File: src/tht_track.sv
// ----------------------------------------------------------------------------
// Tilt gesture debounce tracker
// Holds the candidate timing state, scales confidence and registers the result.
// ----------------------------------------------------------------------------
module tht_track
  import tht_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  item_t      item_i,
  input  cls_t       cls_i,
  input  cfg_t       cfg_i,
  output logic       take_o,
  tht_out_if.source  out_o
);

  gesture_e          last_cand_q, last_cand_d;
  logic [31:0]       hold_start_q, hold_start_d;
  logic              confirmed_q, confirmed_d;
  logic              out_valid_q;
  result_t           out_res_q, res_d;
  logic              fire, stale, hold_met;
  logic [31:0]       elapsed;
  logic [ProdW-1:0]  product;
  logic [QuotW-1:0]  quotient;
  logic [15:0]       conf;

  // The result register frees up when empty or when its item is taken.
  assign take_o      = !out_valid_q || out_o.ready;
  assign fire        = valid_i && take_o;
  assign out_o.valid = out_valid_q;
  assign out_o.res   = out_res_q;

  // Frame age check and hold timer; the difference wraps modulo 2^32.
  assign stale    = item_i.frame_age_ms > cfg_i.stale_limit_ms;
  assign elapsed  = item_i.now_ms - hold_start_q;
  assign hold_met = elapsed >= {16'b0, cfg_i.hold_time_ms};

  // Divide by 45 through the scaled reciprocal, then clip to 1.0.
  assign product  = ProdW'(cls_i.dividend) * ProdW'(RECIP_45);
  assign quotient = product[ProdW-1:RecipSh];
  assign conf     = (quotient > QuotW'(CONF_ONE)) ? CONF_ONE : quotient[15:0];

  // Debounce state transition and result for the item in the input register.
  always_comb begin
    last_cand_d  = last_cand_q;
    hold_start_d = hold_start_q;
    confirmed_d  = confirmed_q;
    res_d        = '0;
    if (stale) begin
      last_cand_d  = GEST_NONE;
      hold_start_d = '0;
      confirmed_d  = 1'b0;
    end else if (cls_i.cand != last_cand_q) begin
      last_cand_d  = cls_i.cand;
      hold_start_d = item_i.now_ms;
      confirmed_d  = 1'b0;
    end else if (cls_i.cand != GEST_NONE) begin
      confirmed_d = confirmed_q || hold_met;
      if (confirmed_d) begin
        res_d.gesture_code = cls_i.cand;
        res_d.confidence   = conf;
      end
    end
  end

  // Control state and the result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_cand_q  <= GEST_NONE;
      hold_start_q <= '0;
      confirmed_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (fire) begin
        last_cand_q  <= last_cand_d;
        hold_start_q <= hold_start_d;
        confirmed_q  <= confirmed_d;
      end
      if (take_o) begin
        out_valid_q <= fire;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= res_d;
    end
  end

endmodule

// File: src/two_hand_tilt_gesture_debouncer.sv
// ----------------------------------------------------------------------------
// Two-hand tilt gesture debouncer
// Classifies two-hand tilt into gestures and confirms them after a hold time.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   carries one attitude item per handshake: both hands' pitch and roll,
//          the second hand's frame age and a millisecond timestamp.
//   out_o  returns exactly one result item per input item: a gesture code and
//          a confidence where 32768 means 1.0 (both zero until confirmed).
//   cfg_i  writes thresholds and time limits by register index; it is always
//          ready and should be used only while no item is in flight.
// An accepted item is held in the input register, where classification, debounce
// and the divide-by-45 scaling run, and its result loads into the result
// register once that register can take it. Throughput is one item per cycle
// while the receiver keeps out_o.ready high; the single multiplier in the
// confidence scaling sets the path length.
// Reset clears the debounce state and restores all register defaults.
// When the receiver stalls, the result is held, the input register fills and
// in_i.ready drops until out_o.ready returns.
// ----------------------------------------------------------------------------
module two_hand_tilt_gesture_debouncer
  import tht_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  tht_in_if.sink     in_i,
  tht_out_if.source  out_o,
  tht_cfg_if.sink    cfg_i
);

  cfg_t  cfg;
  cls_t  cls;
  item_t s1_item_q;
  logic  s1_valid_q;
  logic  take;

  // Register file.
  tht_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Input register; it moves on whenever the result register can take an item.
  assign in_i.ready = !s1_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_item_q <= in_i.item;
    end
  end

  // Threshold rules.
  tht_classify u_classify (
    .item_i (s1_item_q),
    .cfg_i  (cfg),
    .cls_o  (cls)
  );

  // Debounce state and result register.
  tht_track u_track (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid_q),
    .item_i  (s1_item_q),
    .cls_i   (cls),
    .cfg_i   (cfg),
    .take_o  (take),
    .out_o   (out_o)
  );

  // A result without a gesture carries no confidence.
  a_none_zero_conf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.res.gesture_code == GEST_NONE) |-> out_o.res.confidence == 16'd0)
    else $error("result with no gesture has nonzero confidence");

  // Confidence is clipped at 1.0.
  a_conf_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.res.confidence <= CONF_ONE)
    else $error("confidence above 1.0");

  // A stale frame that moves on yields a no-gesture result in the next cycle.
  a_stale_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && take && (s1_item_q.frame_age_ms > cfg.stale_limit_ms)
    |=> out_o.valid && (out_o.res.gesture_code == GEST_NONE))
    else $error("stale frame produced a gesture");

  // An item that moves on leaves a valid result behind.
  a_item_delivered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && take |=> out_o.valid)
    else $error("item lost between input and result registers");

endmodule

// File: tb/gesture_score_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gesture scoreboard
// Predicts the debounced gesture for every accepted attitude item and checks
// each result item against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
package gesture_score_pkg;
  import tht_pkg::*;

  class gesture_scoreboard;
    // Copy of the register file and of the debounce state.
    cfg_t        cfg;
    gesture_e    last_cand;
    logic [31:0] hold_start;
    bit          confirmed;

    // Predicted results, oldest first.
    result_t     expected_gestures[$];

    int unsigned mismatches;
    int unsigned results_checked;
    int unsigned code_hits[5];

    function new();
      cfg.roll_cross_threshold = ROLL_CROSS_RST;
      cfg.help_lift_threshold  = HELP_LIFT_RST;
      cfg.help_neutral_limit   = HELP_NEUTRAL_RST;
      cfg.lift_threshold       = LIFT_RST;
      cfg.lower_threshold      = LOWER_RST;
      cfg.hold_time_ms         = HOLD_TIME_RST;
      cfg.stale_limit_ms       = STALE_LIMIT_RST;
      last_cand  = GEST_NONE;
      hold_start = '0;
      confirmed  = 1'b0;
      mismatches = 0;
      results_checked = 0;
      foreach (code_hits[i]) code_hits[i] = 0;
    endfunction

    // Mirror one register write; the 15-bit thresholds drop the top data bit.
    function void note_reg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_ROLL_CROSS:   cfg.roll_cross_threshold = data[14:0];
        REG_HELP_LIFT:    cfg.help_lift_threshold  = data[14:0];
        REG_HELP_NEUTRAL: cfg.help_neutral_limit   = data[14:0];
        REG_LIFT:         cfg.lift_threshold       = data[14:0];
        REG_LOWER:        cfg.lower_threshold      = data;
        REG_HOLD_TIME:    cfg.hold_time_ms         = data;
        REG_STALE_LIMIT:  cfg.stale_limit_ms       = data;
        default: ;
      endcase
    endfunction

    function int magnitude(int v);
      return (v < 0) ? -v : v;
    endfunction

    function longint clip_one(longint v);
      return (v > 32768) ? 32768 : v;
    endfunction

    // Priority threshold rules: crossed, help, both up, both down.
    function gesture_e classify(item_t it);
      int fp = it.first_pitch;
      int fr = it.first_roll;
      int sp = it.second_pitch;
      int sr = it.second_roll;
      int rc = int'(cfg.roll_cross_threshold);
      int hl = int'(cfg.help_lift_threshold);
      int hn = int'(cfg.help_neutral_limit);
      int lt = int'(cfg.lift_threshold);
      int lo = cfg.lower_threshold;
      if (fr > rc && sr < -rc) return GEST_CROSSED;
      if (sp > hl && magnitude(fp) < hn && magnitude(fr) < hn) return GEST_HELP;
      if (fp > lt && sp > lt) return GEST_BOTH_UP;
      if (fp < lo && sp < lo) return GEST_BOTH_DOWN;
      return GEST_NONE;
    endfunction

    // Confidence in units of 1/32768, truncated and clipped to 1.0.
    function logic [15:0] confidence_of(gesture_e g, item_t it);
      int fp = it.first_pitch;
      int fr = it.first_roll;
      int sp = it.second_pitch;
      int sr = it.second_roll;
      longint v;
      case (g)
        GEST_HELP:    v = longint'(magnitude(sp)) * 128 / 45;
        GEST_CROSSED: v = longint'(magnitude(fr) + magnitude(sr)) * 32 / 45;
        default:      v = longint'(magnitude(fp + sp)) * 64 / 45;
      endcase
      return 16'(clip_one(v));
    endfunction

    // Advance the debounce state by one accepted item and queue its result.
    function void note_attitude(item_t it);
      result_t     r;
      gesture_e    cand;
      logic [31:0] elapsed;
      r.gesture_code = GEST_NONE;
      r.confidence   = '0;
      if (it.frame_age_ms > cfg.stale_limit_ms) begin
        // A stale second-hand frame drops everything back to the reset state.
        last_cand  = GEST_NONE;
        hold_start = '0;
        confirmed  = 1'b0;
      end else begin
        cand = classify(it);
        if (cand == last_cand && cand != GEST_NONE) begin
          elapsed = it.now_ms - hold_start;
          if (!confirmed && elapsed >= 32'(cfg.hold_time_ms)) confirmed = 1'b1;
          if (confirmed) begin
            r.gesture_code = cand;
            r.confidence   = confidence_of(cand, it);
          end
        end else if (cand != last_cand) begin
          last_cand  = cand;
          hold_start = it.now_ms;
          confirmed  = 1'b0;
        end
      end
      expected_gestures.push_back(r);
    endfunction

    function void report(string what, result_t want, result_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: %s: expected gesture %0d confidence %0d, got gesture %0d confidence %0d",
                 results_checked, what, want.gesture_code, want.confidence,
                 got.gesture_code, got.confidence);
    endfunction

    // Compare one accepted result item with the oldest prediction.
    function void check_gesture(result_t got);
      result_t want;
      results_checked++;
      if (expected_gestures.size() == 0) begin
        want = '0;
        report("unexpected result item", want, got);
        return;
      end
      want = expected_gestures.pop_front();
      if (got.gesture_code != want.gesture_code) report("gesture code differs", want, got);
      else if (got.confidence != want.confidence) report("confidence differs", want, got);
      else if (got.gesture_code <= 3'd4) code_hits[got.gesture_code]++;
    endfunction

    function int unsigned pending();
      return expected_gestures.size();
    endfunction
  endclass

endpackage

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Two-hand tilt gesture debouncer testbench
// Drives directed and random attitude items through the debouncer under five
// register settings, with random stalls on both channels, and checks every
// result item against a scoreboard prediction.
// ----------------------------------------------------------------------------
module testbench;
  import tht_pkg::*;
  import gesture_score_pkg::*;

  localparam int unsigned HalfPeriod    = 4;
  localparam int unsigned ResetCycles   = 8;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned HoldOffCycles = 64;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned ItemsPerPhase = 200;
  localparam int unsigned PauseAtItem   = 420;
  localparam int unsigned HoldOffAtItem = 650;
  localparam int          AngleMax      = 23040;
  localparam logic [CfgIdxW-1:0] RegUnmapped = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni;

  tht_in_if  in_if ();
  tht_out_if out_if ();
  tht_cfg_if cfg_if ();

  two_hand_tilt_gesture_debouncer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  gesture_scoreboard sb;

  int unsigned items_sent    = 0;
  int unsigned send_idle_pct = 15;
  int unsigned recv_idle_pct = 69;
  int unsigned hold_left     = 0;
  logic        hold_off_req  = 1'b0;
  bit          hold_off_done = 1'b0;
  bit          pause_done    = 1'b0;
  logic [31:0] clock_ms;
  int unsigned cycle_count   = 0;

  always #(HalfPeriod) clk_i = ~clk_i;

  // Result side: check accepted items, then pick ready for the next edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) sb.check_gesture(out_if.res);
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_off_req) begin
      out_if.ready <= 1'b0;
      hold_left <= HoldOffCycles;
      hold_off_req <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int pick(int lo, int hi);
    if (lo > hi) return hi;
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // Angle beyond a positive threshold, past the nominal range if needed.
  function automatic int above(int thr);
    return pick(thr + 1, (thr + 1 > AngleMax) ? 32767 : AngleMax);
  endfunction

  function automatic int below(int thr);
    return pick((thr - 1 < -AngleMax) ? -32768 : -AngleMax, thr - 1);
  endfunction

  function automatic logic [15:0] fresh_age();
    if ($urandom_range(9) == 0)
      return 16'(pick(int'(sb.cfg.stale_limit_ms) + 1, 65535));
    return 16'(pick(0, int'(sb.cfg.stale_limit_ms)));
  endfunction

  // Build an item aimed at one gesture under the current thresholds.
  function automatic item_t shaped_item(gesture_e g, logic [31:0] now, logic [15:0] age);
    item_t it;
    int fp = pick(-AngleMax, AngleMax);
    int fr = pick(-AngleMax, AngleMax);
    int sp = pick(-AngleMax, AngleMax);
    int sr = pick(-AngleMax, AngleMax);
    int hn = int'(sb.cfg.help_neutral_limit);
    case (g)
      GEST_CROSSED: begin
        fr = above(int'(sb.cfg.roll_cross_threshold));
        sr = -above(int'(sb.cfg.roll_cross_threshold));
      end
      GEST_HELP: begin
        sp = above(int'(sb.cfg.help_lift_threshold));
        fp = pick(1 - hn, hn - 1);
        fr = pick(1 - hn, hn - 1);
      end
      GEST_BOTH_UP: begin
        fp = above(int'(sb.cfg.lift_threshold));
        sp = above(int'(sb.cfg.lift_threshold));
        fr = pick(-1000, 1000);
      end
      GEST_BOTH_DOWN: begin
        fp = below(sb.cfg.lower_threshold);
        sp = below(sb.cfg.lower_threshold);
        fr = pick(-1000, 1000);
      end
      default: begin
        fp = pick(-1500, 1500);
        fr = pick(-1500, 1500);
        sp = pick(-1500, 1500);
        sr = pick(-1500, 1500);
      end
    endcase
    it.first_pitch  = 16'(fp);
    it.first_roll   = 16'(fr);
    it.second_pitch = 16'(sp);
    it.second_roll  = 16'(sr);
    it.frame_age_ms = age;
    it.now_ms       = now;
    return it;
  endfunction

  function automatic item_t noise_item();
    item_t it;
    it.first_pitch  = 16'($urandom);
    it.first_roll   = 16'($urandom);
    it.second_pitch = 16'($urandom);
    it.second_roll  = 16'($urandom);
    it.frame_age_ms = 16'($urandom);
    it.now_ms       = $urandom;
    return it;
  endfunction

  // Offer one item after a random gap and wait for it to be taken.
  task automatic send_item(input item_t it);
    if (items_sent < 280) begin
      send_idle_pct = 15;
      recv_idle_pct = 69;
    end else if (items_sent < 560) begin
      send_idle_pct = 69;
      recv_idle_pct = 15;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.item  <= it;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_attitude(it);
    items_sent++;
  endtask

  task automatic send_attitude(input int fp, input int fr, input int sp, input int sr,
                               input int unsigned age, input logic [31:0] now);
    item_t it;
    it.first_pitch  = 16'(fp);
    it.first_roll   = 16'(fr);
    it.second_pitch = 16'(sp);
    it.second_roll  = 16'(sr);
    it.frame_age_ms = 16'(age);
    it.now_ms       = now;
    send_item(it);
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Register writes leave valid high between back-to-back writes.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.note_reg_write(idx, data);
  endtask

  // Program all registers; junk sets the unused top bit of the 15-bit ones
  // and adds a write to an unmapped index.
  task automatic apply_settings(input cfg_t s, input bit junk);
    write_reg(REG_ROLL_CROSS,   {junk, s.roll_cross_threshold});
    write_reg(REG_HELP_LIFT,    {junk, s.help_lift_threshold});
    write_reg(REG_HELP_NEUTRAL, {junk, s.help_neutral_limit});
    write_reg(REG_LIFT,         {junk, s.lift_threshold});
    write_reg(REG_LOWER,        s.lower_threshold);
    write_reg(REG_HOLD_TIME,    s.hold_time_ms);
    write_reg(REG_STALE_LIMIT,  s.stale_limit_ms);
    if (junk) write_reg(RegUnmapped, 16'($urandom));
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic cfg_t random_settings();
    cfg_t s;
    s.roll_cross_threshold = 15'(pick(0, AngleMax));
    s.help_lift_threshold  = 15'(pick(0, AngleMax));
    s.help_neutral_limit   = 15'(pick(0, AngleMax));
    s.lift_threshold       = 15'(pick(0, AngleMax));
    s.lower_threshold      = 16'(pick(-AngleMax, 0));
    s.hold_time_ms         = 16'(pick(0, 2000));
    s.stale_limit_ms       = 16'(pick(0, 65535));
    return s;
  endfunction

  // Mostly well-formed gesture holds with random content, the rest noise.
  task automatic run_random(input int unsigned quota);
    int unsigned start;
    int unsigned len;
    int unsigned step_max;
    gesture_e    g;
    start = items_sent;
    clock_ms = $urandom;
    while (items_sent - start < quota) begin
      if ($urandom_range(99) < 15) begin
        send_item(noise_item());
      end else begin
        g = gesture_e'($urandom_range(4));
        len = $urandom_range(8, 1);
        step_max = sb.cfg.hold_time_ms / 3 + 20;
        if ($urandom_range(19) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(step_max);
        repeat (len) begin
          clock_ms += $urandom_range(step_max);
          send_item(shaped_item(g, clock_ms, fresh_age()));
        end
      end
      // Sender pause until everything is back, once.
      if (!pause_done && items_sent >= PauseAtItem) begin
        pause_done = 1'b1;
        drain();
      end
      // Long receiver hold-off while items keep coming, once.
      if (!hold_off_done && items_sent >= HoldOffAtItem) begin
        hold_off_done = 1'b1;
        hold_off_req <= 1'b1;
      end
    end
  endtask

  // Directed items under the reset settings: hold 500 ms, stale above 200 ms.
  task automatic run_directed();
    // Most negative angles: both down, then confirmed with saturated confidence.
    send_attitude(-32768, -32768, -32768, -32768, 0, 32'd0);
    send_attitude(-32768, -32768, -32768, -32768, 0, 32'd500);
    // Most positive angles, then a stale frame, then age equal to the limit.
    send_attitude(32767, 32767, 32767, 32767, 0, 32'd600);
    send_attitude(32767, 32767, 32767, 32767, 16'hFFFF, 32'd700);
    send_attitude(32767, 32767, 32767, 32767, 200, 32'hFFFF_FFFF);
    send_attitude(0, 0, 0, 0, 0, 32'd1000);
    // Crossed wins over both up; confirmation exactly at the hold time.
    send_attitude(5000, 23040, 5000, -23040, 0, 32'd1000);
    send_attitude(5000, 23040, 5000, -23040, 0, 32'd1499);
    send_attitude(5000, 23040, 5000, -23040, 0, 32'd1500);
    send_attitude(0, 3841, 0, -3841, 0, 32'd1600);
    // Help with the first hand just inside the neutral band.
    send_attitude(1919, -1919, 4000, 0, 0, 32'd2000);
    send_attitude(1919, -1919, 4000, 0, 0, 32'd2500);
    send_attitude(1920, 0, 4000, 0, 0, 32'd2600);
    // Both up and both down just past their thresholds.
    send_attitude(3841, 0, 3841, 0, 0, 32'd3000);
    send_attitude(3841, 0, 3841, 0, 0, 32'd3500);
    send_attitude(-3841, 0, -3841, 0, 0, 32'd4000);
    send_attitude(-3841, 0, -3841, 0, 0, 32'd4499);
    send_attitude(-3841, 0, -3841, 0, 0, 32'd4500);
    send_attitude(-3840, 0, -3841, 0, 0, 32'd4600);
    // Hold time measured across the timestamp wrap.
    send_attitude(0, 8000, 0, -8000, 0, 32'hFFFF_FF00);
    send_attitude(0, 8000, 0, -8000, 0, 32'h0000_00F4);
    send_attitude(0, 8000, 0, -8000, 201, 32'h0000_0100);
  endtask

  initial begin
    cfg_t s;
    sb = new();
    in_if.valid  = 1'b0;
    in_if.item   = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data  = '0;
    rst_ni = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    drain();

    // Lowest settings: every threshold at zero, no hold time, any nonzero age is stale.
    s = '0;
    apply_settings(s, 1'b0);
    run_random(ItemsPerPhase);
    drain();

    s = random_settings();
    apply_settings(s, 1'b1);
    run_random(ItemsPerPhase);
    drain();

    // Highest settings: gestures need out-of-range angles, longest hold.
    s.roll_cross_threshold = 15'(AngleMax);
    s.help_lift_threshold  = 15'(AngleMax);
    s.help_neutral_limit   = 15'(AngleMax);
    s.lift_threshold       = 15'(AngleMax);
    s.lower_threshold      = 16'(-AngleMax);
    s.hold_time_ms         = 16'hFFFF;
    s.stale_limit_ms       = 16'hFFFF;
    apply_settings(s, 1'b0);
    run_random(ItemsPerPhase);
    drain();

    s = random_settings();
    apply_settings(s, 1'b1);
    run_random(ItemsPerPhase);
    drain();

    $display("Sent %0d attitude items under five register settings; %0d results checked.",
             items_sent, sb.results_checked);
    $display("Confirmed gestures seen: up %0d, down %0d, crossed %0d, help %0d; mismatches %0d.",
             sb.code_hits[GEST_BOTH_UP], sb.code_hits[GEST_BOTH_DOWN],
             sb.code_hits[GEST_CROSSED], sb.code_hits[GEST_HELP], sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
src/tht_pkg.sv
src/tht_if.sv
src/tht_cfg_regs.sv
src/tht_classify.sv
src/tht_track.sv
src/two_hand_tilt_gesture_debouncer.sv
tb/gesture_score_pkg.sv
tb/testbench.sv
